// ===== src/sed_pkg.sv =====
// Shared types and constants for the sequence edit distance block.
// No dependencies; used by the channel interfaces and all RTL modules.
`default_nettype none

package sed_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  // DP values stay within the larger of row and column index; one bit above the length
  localparam int DP_W    = LEN_W + 1;
  localparam int VAL_W   = 64;
  localparam int OP_W    = 2;
  localparam int DIST_W  = 11;

  typedef logic [OP_W-1:0]          op_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic [DP_W-1:0]          dp_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [DIST_W-1:0]        dist_t;

  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_ROW    = 2'd1;
  localparam op_t OP_FINISH = 2'd2;

endpackage

`default_nettype wire

// ===== src/sed_in_if.sv =====
// Input channel: one beat carries an op code and a sequence element.
// Depends on sed_pkg.
`default_nettype none

interface sed_in_if;
  logic              valid;
  logic              ready;
  sed_pkg::op_t      op;
  sed_pkg::val_t     value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

// ===== src/sed_out_if.sv =====
// Result channel: one beat carries the distance and the overflow flag.
// Depends on sed_pkg.
`default_nettype none

interface sed_out_if;
  logic              valid;
  logic              ready;
  sed_pkg::dist_t    distance;
  logic              overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/sed_cell.sv =====
// One DP cell: element match plus min of insert, delete and substitute.
// Depends on sed_pkg.
`default_nettype none

module sed_cell (
  input  sed_pkg::dp_t   prev,
  input  sed_pkg::dp_t   left,
  input  sed_pkg::dp_t   diag,
  input  sed_pkg::val_t  a,
  input  sed_pkg::val_t  b,
  output sed_pkg::dp_t   result
);
  import sed_pkg::*;

  dp_t up_c;
  dp_t left_c;
  dp_t diag_c;
  dp_t m01;

  always_comb begin
    up_c   = prev + dp_t'(1);
    left_c = left + dp_t'(1);
    diag_c = (a == b) ? diag : diag + dp_t'(1);
    m01    = (up_c < left_c) ? up_c : left_c;
    result = (m01 < diag_c) ? m01 : diag_c;
  end

endmodule

`default_nettype wire

// ===== src/sequence_edit_distance.sv =====
// Top level of the sequence edit distance block; holds the element store,
// the DP column memory and the sweep sequencer. Depends on sed_pkg,
// sed_in_if, sed_out_if and sed_cell.
`default_nettype none

// Levenshtein distance between two sequences of 64-bit elements. An append
// (op 0) writes the element store and the column memory on acceptance. A
// second-sequence element (op 1) sweeps one DP row through a single shared
// cell, one column entry per cycle against the column memory's read/write
// ports; a dropped element (beyond MAX_LEN) starts no sweep. A finish (op 2)
// reads the last column entry, then waits for the result register to free
// up. Both memories start undefined and need no clearing pass after reset.
// The input is not ready while a sweep or a finish is in progress.
module sequence_edit_distance (
  input  logic       clk,
  input  logic       rst,
  sed_in_if.sink     items,
  sed_out_if.source  results
);
  import sed_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_FIN} state_t;

  state_t state;
  len_t   first_len;
  len_t   second_count;
  logic   ovf;
  dp_t    col0;
  len_t   idx;
  logic   p_vld;
  addr_t  p_addr;
  dp_t    left;
  dp_t    diag;
  val_t   cmp_val;
  logic   fin_zero;
  logic   out_valid;
  dist_t  out_dist;
  logic   out_ovf;

  val_t   store_mem [MAX_LEN];
  dp_t    col_mem   [MAX_LEN];
  val_t   store_rdata;
  dp_t    col_rdata;

  logic   acc;
  logic   sweep_rd;
  logic   rd_en;
  addr_t  rd_addr;
  logic   app_we;
  logic   col_we;
  addr_t  col_wa;
  dp_t    col_wd;
  dp_t    cell_out;
  logic   out_free;

  assign items.ready      = (state == S_IDLE);
  assign results.valid    = out_valid;
  assign results.distance = out_dist;
  assign results.overflow = out_ovf;

  always_comb begin
    acc      = items.valid && items.ready;
    sweep_rd = (state == S_SWEEP) && (idx < first_len);
    rd_en    = sweep_rd || (acc && items.op == OP_FINISH);
    rd_addr  = (state == S_SWEEP) ? idx[ADDR_W-1:0] : addr_t'(first_len - len_t'(1));
    app_we   = acc && items.op == OP_APPEND && first_len != len_t'(MAX_LEN);
    // sweep writeback and append never overlap: append only in idle
    col_we   = app_we || p_vld;
    col_wa   = p_vld ? p_addr : first_len[ADDR_W-1:0];
    col_wd   = p_vld ? cell_out : dp_t'(first_len) + dp_t'(1);
    out_free = !out_valid || results.ready;
  end

  always_ff @(posedge clk) begin
    if (app_we) begin
      store_mem[first_len[ADDR_W-1:0]] <= items.value;
    end
    if (rd_en) begin
      store_rdata <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    if (rd_en) begin
      col_rdata <= col_mem[rd_addr];
    end
  end

  sed_cell u_cell (
    .prev   (col_rdata),
    .left   (left),
    .diag   (diag),
    .a      (store_rdata),
    .b      (cmp_val),
    .result (cell_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      first_len    <= '0;
      second_count <= '0;
      ovf          <= 1'b0;
      col0         <= '0;
      idx          <= '0;
      p_vld        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // S_FIN refills the result register itself when it drains
      if (out_valid && results.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            case (items.op)
              OP_APPEND: begin
                if (first_len != len_t'(MAX_LEN)) begin
                  first_len <= first_len + len_t'(1);
                end else begin
                  ovf <= 1'b1;
                end
              end
              OP_ROW: begin
                if (second_count != len_t'(MAX_LEN)) begin
                  second_count <= second_count + len_t'(1);
                  col0         <= dp_t'(second_count) + dp_t'(1);
                  left         <= dp_t'(second_count) + dp_t'(1);
                  diag         <= dp_t'(second_count);
                  cmp_val      <= items.value;
                  idx          <= '0;
                  p_vld        <= 1'b0;
                  state        <= S_SWEEP;
                end else begin
                  ovf <= 1'b1;
                end
              end
              OP_FINISH: begin
                fin_zero <= (first_len == '0);
                state    <= S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_SWEEP: begin
          // read entry idx while writing back the entry read in the previous cycle
          p_vld  <= sweep_rd;
          p_addr <= idx[ADDR_W-1:0];
          if (sweep_rd) begin
            idx <= idx + len_t'(1);
          end
          if (p_vld) begin
            left <= cell_out;
            diag <= col_rdata;
          end
          if (!sweep_rd && !p_vld) begin
            state <= S_IDLE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_dist     <= fin_zero ? col0[DIST_W-1:0] : col_rdata[DIST_W-1:0];
            out_ovf      <= ovf;
            out_valid    <= 1'b1;
            first_len    <= '0;
            second_count <= '0;
            ovf          <= 1'b0;
            col0         <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_sequence_edit_distance.sv =====
// Testbench for sequence_edit_distance: directed table and random sequences,
// scored against a behavioral edit distance predictor or typed table values.
// Depends on sed_pkg, sed_in_if, sed_out_if and the block under test.
`default_nettype none

module tb_sequence_edit_distance;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  localparam op_t OP_UNUSED   = 2'd3;
  localparam int  GAP_PCT     = 21;
  localparam int  WATCHDOG    = 20000;
  localparam int  RANDOM_BEATS = 550;
  localparam int  RANDOM_DISTS = 36;

  typedef struct packed {
    dist_t distance;
    logic  overflow;
  } dist_result_t;

  typedef struct packed {
    op_t   op;
    val_t  value;
    logic  typed;
    dist_t distance;
    logic  overflow;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  sed_in_if  items_ch ();
  sed_out_if results_ch ();

  sequence_edit_distance dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  val_t        first_elems [MAX_LEN];
  int unsigned dp_col [MAX_LEN + 1];
  int unsigned first_count;
  int unsigned second_count;
  logic        dropped;

  dist_result_t pending_dists [$];
  int  error_count = 0;
  bit  sender_gaps = 1'b1;
  bit  receiver_stalls = 1'b1;
  int  random_beats = 0;
  int  random_dists = 0;
  int  quiet_cycles = 0;

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Updates the predictor for one beat; returns 1 when a distance comes out.
  function automatic bit edit_distance_step(input op_t op, input val_t v,
                                            output dist_result_t res);
    int unsigned diag, prev, best, cand;
    res = '0;
    case (op)
      OP_APPEND: begin
        if (first_count < MAX_LEN) begin
          first_elems[first_count] = v;
          first_count++;
          dp_col[first_count] = first_count;
        end else begin
          dropped = 1'b1;
        end
      end
      OP_ROW: begin
        if (second_count >= MAX_LEN) begin
          dropped = 1'b1;
        end else begin
          second_count++;
          diag = second_count - 1;
          dp_col[0] = second_count;
          for (int unsigned y = 1; y <= first_count; y++) begin
            prev = dp_col[y];
            best = prev + 1;
            cand = dp_col[y-1] + 1;
            if (cand < best) best = cand;
            cand = diag + ((first_elems[y-1] == v) ? 0 : 1);
            if (cand < best) best = cand;
            dp_col[y] = best;
            diag = prev;
          end
        end
      end
      OP_FINISH: begin
        res.distance = dp_col[first_count][DIST_W-1:0];
        res.overflow = dropped;
        first_count = 0;
        second_count = 0;
        dropped = 1'b0;
        dp_col[0] = 0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_item(input op_t op, input val_t v, input bit typed = 1'b0,
                           input dist_t tdist = '0, input logic tovf = 1'b0);
    dist_result_t res;
    while (sender_gaps && $urandom_range(99) < GAP_PCT) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.op    <= op;
    items_ch.value <= v;
    do @(posedge clk); while (!items_ch.ready);
    if (edit_distance_step(op, v, res)) begin
      if (typed) begin
        res.distance = tdist;
        res.overflow = tovf;
      end
      pending_dists = {pending_dists, res};
    end
  endtask

  task automatic wait_drain();
    items_ch.valid <= 1'b0;
    while (pending_dists.size() != 0) @(posedge clk);
  endtask

  // Mostly in-order sequences over a small alphabet; some shuffled with noise.
  task automatic run_random_sequence();
    val_t alphabet [4];
    int   alpha_n, n_first, n_second, sent_first, sent_second;
    bit   shuffled;
    op_t  op;
    val_t v;
    foreach (alphabet[i]) alphabet[i] = {$urandom, $urandom};
    alpha_n  = $urandom_range(4, 1);
    n_first  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
    n_second = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
    shuffled = ($urandom_range(99) < 15);
    sent_first = 0;
    sent_second = 0;
    while (sent_first < n_first || sent_second < n_second) begin
      if (shuffled && $urandom_range(3) == 0)
        send_item(OP_UNUSED, {$urandom, $urandom});
      if (sent_first < n_first &&
          (!shuffled || sent_second == n_second || $urandom_range(1) == 1)) begin
        op = OP_APPEND;
        sent_first++;
      end else begin
        op = OP_ROW;
        sent_second++;
      end
      v = ($urandom_range(9) == 0) ? val_t'({$urandom, $urandom})
                                   : alphabet[$urandom_range(alpha_n - 1)];
      send_item(op, v);
      random_beats++;
    end
    send_item(OP_FINISH, {$urandom, $urandom});
    random_beats++;
    random_dists++;
  endtask

  // result side: random stalls, in-order compare
  always @(posedge clk) begin
    dist_result_t exp_res;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_dists.size() == 0) begin
        flag_mismatch($sformatf("unexpected result distance=%0d overflow=%0b",
                                results_ch.distance, results_ch.overflow));
      end else begin
        exp_res = pending_dists.pop_front();
        if (results_ch.distance !== exp_res.distance)
          flag_mismatch($sformatf("distance %0d, expected %0d",
                                  results_ch.distance, exp_res.distance));
        if (results_ch.overflow !== exp_res.overflow)
          flag_mismatch($sformatf("overflow %0b, expected %0b",
                                  results_ch.overflow, exp_res.overflow));
      end
    end
    results_ch.ready <= !rst && !(receiver_stalls && $urandom_range(99) < GAP_PCT);
  end

  always @(posedge clk) begin
    if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [25];
    int        seq_idx;

    plan = '{
      '{OP_FINISH, 64'h0, 1'b1, 11'd0, 1'b0},           // both empty after reset
      '{OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 11'd0, 1'b0},
      '{OP_FINISH, 64'h0, 1'b1, 11'd0, 1'b0},
      '{OP_APPEND, 64'h8000_0000_0000_0000, 1'b0, 11'd0, 1'b0},
      '{OP_APPEND, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 11'd0, 1'b0},
      '{OP_FINISH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 11'd2, 1'b0}, // second empty
      '{OP_ROW,    64'h1, 1'b0, 11'd0, 1'b0},
      '{OP_ROW,    64'h2, 1'b0, 11'd0, 1'b0},
      '{OP_ROW,    64'h3, 1'b0, 11'd0, 1'b0},
      '{OP_FINISH, 64'h0, 1'b1, 11'd3, 1'b0},           // first empty
      '{OP_APPEND, 64'h5, 1'b0, 11'd0, 1'b0},
      '{OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 11'd0, 1'b0},
      '{OP_ROW,    64'h5, 1'b0, 11'd0, 1'b0},
      '{OP_ROW,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 11'd0, 1'b0},
      '{OP_FINISH, 64'h0, 1'b1, 11'd0, 1'b0},           // identical sequences
      '{OP_APPEND, 64'hA, 1'b0, 11'd0, 1'b0},
      '{OP_APPEND, 64'hB, 1'b0, 11'd0, 1'b0},
      '{OP_APPEND, 64'hC, 1'b0, 11'd0, 1'b0},
      '{OP_ROW,    64'hA, 1'b0, 11'd0, 1'b0},
      '{OP_ROW,    64'hC, 1'b0, 11'd0, 1'b0},
      '{OP_FINISH, 64'h0, 1'b0, 11'd0, 1'b0},
      '{OP_ROW,    64'h7, 1'b0, 11'd0, 1'b0},           // append after row
      '{OP_APPEND, 64'h7, 1'b0, 11'd0, 1'b0},
      '{OP_APPEND, 64'h8, 1'b0, 11'd0, 1'b0},
      '{OP_FINISH, 64'h0, 1'b0, 11'd0, 1'b0}
    };

    rst = 1'b1;
    items_ch.valid <= 1'b0;
    items_ch.op    <= OP_APPEND;
    items_ch.value <= '0;
    first_count  = 0;
    second_count = 0;
    dropped      = 1'b0;
    dp_col[0]    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_item(plan[i].op, plan[i].value, plan[i].typed, plan[i].distance,
                plan[i].overflow);
    wait_drain();

    seq_idx = 0;
    while (random_beats < RANDOM_BEATS || random_dists < RANDOM_DISTS) begin
      // a run of sequences with both sides streaming flat out
      sender_gaps     = !(seq_idx >= 20 && seq_idx < 30);
      receiver_stalls = sender_gaps;
      run_random_sequence();
      seq_idx++;
      if (seq_idx == 30) wait_drain();
    end

    wait_drain();
    repeat (MAX_LEN + 16) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
